// ===== rtl/has_pkg.sv =====
package has_pkg;

	localparam int MAX_SIZE_D  = 16;
	localparam int COST_BITS_D = 16;
	localparam int WORK_BITS_D = 24;
	localparam int CFG_BITS    = 5;

	localparam logic [0:0] REG_COLUMNS = 1'b0;
	localparam logic [0:0] REG_ROWS    = 1'b1;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_RED_MIN,
		ST_RED_SUB,
		ST_RED_STAR,
		ST_COVER,
		ST_FIND,
		ST_AUG,
		ST_MIN,
		ST_ADD,
		ST_SUB,
		ST_EMIT
	} state_t;

	// Memory access request from the sequencer to the datapath.
	typedef struct packed {
		logic rd;
		logic wr_add;
		logic wr_sub;
	} mem_op_t;

endpackage

// ===== rtl/has_ram.sv =====
module has_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/hungarian_assignment_solver_unit.sv =====
// Minimum-cost assignment solver. Load a cost matrix of rows_in_use rows and
// columns_in_use columns, one entry per request in row-major order; after the
// final entry the block runs the Munkres steps and returns one request per
// column, giving the row assigned to it, with last_of_run on the final column.
// Loading accepts one entry per cycle. The solve runs on one memory, with a
// read port and a write port, and one add/subtract/compare unit, through
// matrix sweeps (column minimum, subtract, zero search, smallest uncovered
// entry, add, subtract). Input is not ready during the solve or while results
// are delivered. Configuration writes restart the load.
module hungarian_assignment_solver_unit
	import has_pkg::*;
#(
	parameter int MAX_SIZE  = has_pkg::MAX_SIZE_D,
	parameter int COST_BITS = has_pkg::COST_BITS_D,
	parameter int WORK_BITS = has_pkg::WORK_BITS_D
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [has_pkg::CFG_BITS-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [COST_BITS-1:0]          cost,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [3:0]                    column_index,
	output logic [3:0]                    assigned_row,
	output logic                          last_of_run
);
	localparam int IW = $clog2(MAX_SIZE);
	localparam int NW = $clog2(MAX_SIZE + 1);
	localparam int AW = 2 * IW;
	localparam logic [WORK_BITS-1:0] WMAX = {WORK_BITS{1'b1}};

	state_t state_q, state_d;

	logic [CFG_BITS-1:0] cols_cfg_q, rows_cfg_q;
	logic [NW-1:0] nr, nc, cclamp;
	logic [AW:0]   load_q;
	logic [AW:0]   total;

	// Star/prime marks: 1-based, zero means none.
	logic [IW:0] star_col_q [MAX_SIZE];
	logic [IW:0] star_row_q [MAX_SIZE];
	logic [IW:0] prime_q    [MAX_SIZE];
	logic [MAX_SIZE-1:0] ccov_q, rcov_q;

	// Sweep counters: i is row, j column. rd_vld_q marks the registered read.
	logic [IW-1:0] i_q, j_q, ri_q, rj_q;
	logic          rd_vld_q, sweep_done_q;
	logic [WORK_BITS-1:0] lo_q;
	logic [IW-1:0] best_q;
	logic [IW:0]   path_q;
	logic [NW:0]   guard_q;
	logic [IW-1:0] emit_q;

	logic                 we;
	logic [AW-1:0]        waddr, raddr;
	logic [WORK_BITS-1:0] wdata, rdata;

	function automatic logic [NW-1:0] clampf(input logic [CFG_BITS-1:0] v);
		logic [NW-1:0] r;
		if (v == '0) r = NW'(1);
		else if (32'(v) > MAX_SIZE) r = NW'(MAX_SIZE);
		else r = NW'(v);
		return r;
	endfunction

	assign nr     = clampf(rows_cfg_q);
	assign cclamp = clampf(cols_cfg_q);
	assign nc     = (cclamp > nr) ? nr : cclamp;
	assign total  = (AW+1)'(nr * nc);

	function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c,
		input logic [NW-1:0] ncols);
		return AW'(r * ncols + c);
	endfunction

	has_ram #(.WIDTH(WORK_BITS), .DEPTH(MAX_SIZE * MAX_SIZE)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// Sweep order: column-major (j outer, i inner), last at i=nr-1, j=nc-1.
	logic last_i, last_j;
	assign last_i = (NW'(i_q) == nr - NW'(1));
	assign last_j = (NW'(j_q) == nc - NW'(1));
	assign raddr  = addr(i_q, j_q, nc);

	logic zero_hit;
	assign zero_hit = rd_vld_q && !ccov_q[rj_q] && !rcov_q[ri_q] && (rdata == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:     if (in_valid && in_ready && load_q + 1'b1 >= total) state_d = ST_RED_MIN;
			ST_EMIT:     if (out_ready && NW'(emit_q) == nc - NW'(1)) state_d = ST_LOAD;
			default:     ;
		endcase
	end

	assign in_ready     = (state_q == ST_LOAD);
	assign out_valid    = (state_q == ST_EMIT);
	assign column_index = 4'(emit_q);
	assign assigned_row = (star_col_q[emit_q] == '0) ? 4'd0 : 4'(star_col_q[emit_q] - 1'b1);
	assign last_of_run  = (NW'(emit_q) == nc - NW'(1));

	// Write port: load, subtract, add.
	always_comb begin
		we = 1'b0;
		waddr = addr(ri_q, rj_q, nc);
		wdata = rdata;
		case (state_q)
			ST_LOAD: begin
				we = in_valid;
				waddr = (load_q >= total) ? '0 : load_q[AW-1:0];
				wdata = WORK_BITS'(cost);
			end
			ST_RED_SUB: begin
				we = rd_vld_q;
				wdata = rdata - lo_q;
			end
			ST_ADD: begin
				we = rd_vld_q && rcov_q[ri_q];
				wdata = (rdata > WMAX - lo_q) ? WMAX : rdata + lo_q;
			end
			ST_SUB: begin
				we = rd_vld_q && !ccov_q[rj_q];
				wdata = (rdata < lo_q) ? '0 : rdata - lo_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cols_cfg_q <= CFG_BITS'(16);
			rows_cfg_q <= CFG_BITS'(16);
			load_q <= '0;
			ccov_q <= '0;
			rcov_q <= '0;
			i_q <= '0; j_q <= '0; ri_q <= '0; rj_q <= '0;
			rd_vld_q <= 1'b0;
			sweep_done_q <= 1'b0;
			lo_q <= '0; best_q <= '0; path_q <= '0; guard_q <= '0; emit_q <= '0;
			for (int k = 0; k < MAX_SIZE; k++) begin
				star_col_q[k] <= '0; star_row_q[k] <= '0; prime_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_COLUMNS) cols_cfg_q <= cfg_data;
				else rows_cfg_q <= cfg_data;
				load_q <= '0;
			end
			// Default sweep stepping: issue a read, register address pair.
			ri_q <= i_q; rj_q <= j_q;
			rd_vld_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (in_valid && !cfg_we) begin
						if (load_q + 1'b1 >= total || load_q >= total) begin
							load_q <= (load_q >= total && total != (AW+1)'(1)) ? (AW+1)'(1) : '0;
						end else begin
							load_q <= load_q + 1'b1;
						end
					end
					if (in_valid && load_q + 1'b1 >= total && load_q < total) begin
						for (int k = 0; k < MAX_SIZE; k++) begin
							star_col_q[k] <= '0; star_row_q[k] <= '0; prime_q[k] <= '0;
						end
						ccov_q <= '0; rcov_q <= '0; path_q <= '0;
						i_q <= '0; j_q <= '0; sweep_done_q <= 1'b0;
					end
				end
				// Column minimum, one row per cycle.
				ST_RED_MIN: begin
					if (!sweep_done_q) begin
						rd_vld_q <= 1'b1;
						if (last_i) sweep_done_q <= 1'b1; else i_q <= i_q + 1'b1;
					end
					if (rd_vld_q) begin
						if (ri_q == '0 || rdata < lo_q) begin
							lo_q <= rdata; best_q <= ri_q;
						end
						if (sweep_done_q) begin
							state_q <= ST_RED_SUB; i_q <= '0; sweep_done_q <= 1'b0;
						end
					end
				end
				ST_RED_SUB: begin
					if (!sweep_done_q) begin
						rd_vld_q <= 1'b1;
						if (last_i) sweep_done_q <= 1'b1; else i_q <= i_q + 1'b1;
					end
					if (rd_vld_q && sweep_done_q) begin
						state_q <= ST_RED_STAR; i_q <= '0; sweep_done_q <= 1'b0;
						if (star_col_q[j_q] == '0 && star_row_q[best_q] == '0) begin
							star_col_q[j_q] <= (IW+1)'(best_q) + 1'b1;
							star_row_q[best_q] <= (IW+1)'(j_q) + 1'b1;
							state_q <= ST_RED_MIN;
							if (last_j) state_q <= ST_COVER; else j_q <= j_q + 1'b1;
						end
					end
				end
				// Star the first other zero in the column, if free.
				ST_RED_STAR: begin
					if (!sweep_done_q) begin
						rd_vld_q <= 1'b1;
						if (last_i) sweep_done_q <= 1'b1; else i_q <= i_q + 1'b1;
					end
					if (rd_vld_q && ri_q != best_q && rdata == '0 &&
						star_col_q[rj_q] == '0 && star_row_q[ri_q] == '0) begin
						star_col_q[rj_q] <= (IW+1)'(ri_q) + 1'b1;
						star_row_q[ri_q] <= (IW+1)'(rj_q) + 1'b1;
					end
					if (rd_vld_q && sweep_done_q) begin
						i_q <= '0; sweep_done_q <= 1'b0;
						if (last_j) begin
							state_q <= ST_COVER; j_q <= '0;
						end else begin
							state_q <= ST_RED_MIN; j_q <= j_q + 1'b1;
						end
					end
				end
				ST_COVER: begin
					logic all_cov;
					all_cov = 1'b1;
					for (int k = 0; k < MAX_SIZE; k++) begin
						if (k < int'(nc)) begin
							if (star_col_q[k] != '0) ccov_q[k] <= 1'b1;
							else all_cov = 1'b0;
						end
					end
					i_q <= '0; j_q <= '0; sweep_done_q <= 1'b0; emit_q <= '0;
					state_q <= all_cov ? ST_EMIT : ST_FIND;
				end
				// Scan for an uncovered zero; restart after each prime.
				ST_FIND: begin
					if (!sweep_done_q && !zero_hit) begin
						rd_vld_q <= 1'b1;
						if (last_i) begin
							i_q <= '0;
							if (last_j) sweep_done_q <= 1'b1; else j_q <= j_q + 1'b1;
						end else i_q <= i_q + 1'b1;
					end
					if (zero_hit) begin
						prime_q[ri_q] <= (IW+1)'(rj_q) + 1'b1;
						i_q <= '0; j_q <= '0; sweep_done_q <= 1'b0;
						if (star_row_q[ri_q] != '0) begin
							rcov_q[ri_q] <= 1'b1;
							ccov_q[IW'(star_row_q[ri_q] - 1'b1)] <= 1'b0;
						end else begin
							path_q <= (IW+1)'(ri_q) + 1'b1;
							guard_q <= '0;
							state_q <= ST_AUG;
						end
					end else if (rd_vld_q && sweep_done_q) begin
						state_q <= ST_MIN; i_q <= '0; j_q <= '0;
						sweep_done_q <= 1'b0; lo_q <= WMAX;
					end
				end
				// One alternating path step per cycle.
				ST_AUG: begin
					logic [IW-1:0] r, jj;
					r = IW'(path_q - 1'b1);
					jj = IW'(prime_q[r] - 1'b1);
					if (prime_q[r] == '0) begin
						state_q <= ST_COVER;
						prime_q <= '{default: '0}; rcov_q <= '0; ccov_q <= '0;
					end else begin
						star_row_q[r] <= prime_q[r];
						star_col_q[jj] <= path_q;
						path_q <= star_col_q[jj];
						guard_q <= guard_q + 1'b1;
						if (star_col_q[jj] == '0 || 32'(guard_q) + 1 > MAX_SIZE) begin
							state_q <= ST_COVER;
							prime_q <= '{default: '0}; rcov_q <= '0; ccov_q <= '0;
						end
					end
				end
				ST_MIN, ST_ADD, ST_SUB: begin
					if (!sweep_done_q) begin
						rd_vld_q <= 1'b1;
						if (last_i) begin
							i_q <= '0;
							if (last_j) sweep_done_q <= 1'b1; else j_q <= j_q + 1'b1;
						end else i_q <= i_q + 1'b1;
					end
					if (state_q == ST_MIN && rd_vld_q && !ccov_q[rj_q] && !rcov_q[ri_q] &&
						rdata < lo_q) lo_q <= rdata;
					if (rd_vld_q && sweep_done_q) begin
						i_q <= '0; j_q <= '0; sweep_done_q <= 1'b0;
						state_q <= (state_q == ST_MIN) ? ST_ADD :
							(state_q == ST_ADD) ? ST_SUB : ST_FIND;
					end
				end
				ST_EMIT: begin
					if (out_ready) emit_q <= emit_q + 1'b1;
				end
				default: state_q <= ST_LOAD;
			endcase
			if (state_q == ST_LOAD || state_q == ST_EMIT) state_q <= state_d;
		end
	end
endmodule

// ===== bench/testbench.sv =====
// Scoreboard for the assignment solver. It keeps its own copy of the cost
// matrix, the register settings and the star/prime/cover marks. It runs the
// Munkres steps on each completed matrix and queues the per-column assignment
// that the block must report.
class assignment_scoreboard;
	typedef struct {
		bit [3:0] column;
		bit [3:0] row;
		bit       last;
	} assignment_t;

	typedef enum {STEP_COVER, STEP_FIND, STEP_AUGMENT, STEP_NEW_ZEROS, STEP_DONE} solve_step_t;

	localparam int          SIZE     = has_pkg::MAX_SIZE_D;
	localparam bit [23:0]   WORK_TOP = '1;

	bit [23:0]    matrix [SIZE*SIZE];
	int           star_col [SIZE];
	int           star_row [SIZE];
	int           prime_row [SIZE];
	bit           col_cov [SIZE];
	bit           row_cov [SIZE];
	int           loaded;
	int           path_start;
	int           cols_reg;
	int           rows_reg;
	assignment_t  assignments [$];
	int           errors;
	int           matrices;
	int           requests;

	function new();
		foreach (matrix[k]) matrix[k] = '0;
		loaded   = 0;
		cols_reg = 16;
		rows_reg = 16;
		errors   = 0;
		matrices = 0;
		requests = 0;
	endfunction

	// A register write restarts loading of the matrix.
	function void set_register(bit [0:0] index, bit [4:0] value);
		if (index == has_pkg::REG_COLUMNS)
			cols_reg = value;
		else
			rows_reg = value;
		loaded = 0;
	endfunction

	function int fit(int v);
		if (v < 1) return 1;
		if (v > SIZE) return SIZE;
		return v;
	endfunction

	function int row_count();
		return fit(rows_reg);
	endfunction

	function int col_count();
		int c;
		c = fit(cols_reg);
		return (c > row_count()) ? row_count() : c;
	endfunction

	function void clear_marks();
		foreach (prime_row[k]) begin
			prime_row[k] = 0;
			row_cov[k]   = 0;
			col_cov[k]   = 0;
		end
	endfunction

	// Column reduction: subtract each column's minimum and star the zero
	// found there (the first lowest row), or else any free zero in the column.
	function void reduce_columns(int nr, int nc);
		int        best;
		bit [23:0] lo;
		for (int j = 0; j < nc; j++) begin
			best = 0;
			lo   = matrix[j];
			for (int i = 1; i < nr; i++)
				if (matrix[i*nc+j] < lo) begin
					lo   = matrix[i*nc+j];
					best = i;
				end
			for (int i = 0; i < nr; i++)
				matrix[i*nc+j] -= lo;
			if (star_col[j] == 0 && star_row[best] == 0) begin
				star_col[j]    = best + 1;
				star_row[best] = j + 1;
			end else begin
				for (int i = 0; i < nr; i++)
					if (i != best && matrix[i*nc+j] == 0 && star_col[j] == 0 &&
					    star_row[i] == 0) begin
						star_col[j] = i + 1;
						star_row[i] = j + 1;
						break;
					end
			end
		end
	endfunction

	// Primes the first uncovered zero, scanning column by column.
	function solve_step_t prime_zero(int nr, int nc);
		for (int j = 0; j < nc; j++) begin
			if (col_cov[j]) continue;
			for (int i = 0; i < nr; i++)
				if (!row_cov[i] && matrix[i*nc+j] == 0) begin
					prime_row[i] = j + 1;
					if (star_row[i] != 0) begin
						row_cov[i] = 1;
						col_cov[(star_row[i] - 1) % SIZE] = 0;
						return STEP_FIND;
					end
					path_start = i;
					return STEP_AUGMENT;
				end
		end
		return STEP_NEW_ZEROS;
	endfunction

	// Walks the alternating path; a row without a prime ends it early.
	function void flip_path();
		int row, here, r, j, guard;
		row   = path_start + 1;
		guard = 0;
		do begin
			here = row;
			r    = (row - 1) % SIZE;
			if (prime_row[r] == 0) break;
			j           = (prime_row[r] - 1) % SIZE;
			star_row[r] = j + 1;
			row         = star_col[j];
			star_col[j] = here;
			guard++;
		end while (row != 0 && guard <= SIZE);
		clear_marks();
	endfunction

	// Adds the smallest uncovered entry to covered rows (saturating) and
	// takes it from uncovered columns (stopping at zero).
	function void shift_costs(int nr, int nc);
		bit [23:0] lo, v;
		lo = WORK_TOP;
		for (int j = 0; j < nc; j++) begin
			if (col_cov[j]) continue;
			for (int i = 0; i < nr; i++)
				if (!row_cov[i] && matrix[i*nc+j] < lo)
					lo = matrix[i*nc+j];
		end
		for (int i = 0; i < nr; i++) begin
			if (!row_cov[i]) continue;
			for (int j = 0; j < nc; j++) begin
				v = matrix[i*nc+j];
				matrix[i*nc+j] = (v > WORK_TOP - lo) ? WORK_TOP : v + lo;
			end
		end
		for (int j = 0; j < nc; j++) begin
			if (col_cov[j]) continue;
			for (int i = 0; i < nr; i++) begin
				v = matrix[i*nc+j];
				matrix[i*nc+j] = (v < lo) ? '0 : v - lo;
			end
		end
	endfunction

	function void solve_assignment(int nr, int nc);
		solve_step_t step;
		int          covered;
		foreach (star_col[k]) begin
			star_col[k] = 0;
			star_row[k] = 0;
		end
		clear_marks();
		path_start = 0;
		reduce_columns(nr, nc);
		step = STEP_COVER;
		while (step != STEP_DONE) begin
			case (step)
				STEP_COVER: begin
					covered = 0;
					for (int j = 0; j < nc; j++)
						if (star_col[j] != 0) begin
							col_cov[j] = 1;
							covered++;
						end
					step = (covered == nc) ? STEP_DONE : STEP_FIND;
				end
				STEP_FIND:    step = prime_zero(nr, nc);
				STEP_AUGMENT: begin
					flip_path();
					step = STEP_COVER;
				end
				default: begin
					shift_costs(nr, nc);
					step = STEP_FIND;
				end
			endcase
		end
	endfunction

	// Notes one accepted cost request; the last entry of a matrix queues
	// one assignment per column.
	function void note_cost(bit [15:0] value);
		int          nr, nc;
		assignment_t a;
		nr = row_count();
		nc = col_count();
		requests++;
		if (loaded >= nr*nc) loaded = 0;
		matrix[loaded % (SIZE*SIZE)] = 24'(value);
		loaded++;
		if (loaded < nr*nc) return;
		loaded = 0;
		matrices++;
		solve_assignment(nr, nc);
		for (int j = 0; j < nc; j++) begin
			a.column = j[3:0];
			a.row    = (star_col[j] == 0) ? 4'd0 : 4'(star_col[j] - 1);
			a.last   = (j + 1 == nc);
			assignments.push_back(a);
		end
	endfunction

	function void check_result(bit [3:0] column, bit [3:0] row, bit last);
		assignment_t a;
		if (assignments.size() == 0) begin
			$error("unexpected result: column_index %0d assigned_row %0d", column, row);
			errors++;
			return;
		end
		a = assignments.pop_front();
		if (column !== a.column) begin
			$error("column_index: expected %0d, got %0d", a.column, column);
			errors++;
		end
		if (row !== a.row) begin
			$error("assigned_row: expected %0d, got %0d", a.row, row);
			errors++;
		end
		if (last !== a.last) begin
			$error("last_of_run: expected %0d, got %0d", a.last, last);
			errors++;
		end
	endfunction
endclass

module testbench;
	import has_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_COLUMNS;
	logic [4:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] cost = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  column_index;
	logic [3:0]  assigned_row;
	logic        last_of_run;

	assignment_scoreboard sb = new();

	// When set, neither side inserts idle cycles.
	bit          no_gaps = 1'b0;
	int          random_requests = 0;

	hungarian_assignment_solver_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cost(cost),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.column_index(column_index),
		.assigned_row(assigned_row),
		.last_of_run(last_of_run)
	);

	always #5 clk = ~clk;

	// Handshakes are observed at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_cost(cost);
			if (out_valid && out_ready)
				sb.check_result(column_index, assigned_row, last_of_run);
		end
	end

	// Unless no_gaps is set, the receiver stalls for a random number of cycles before each result.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Writes a register; a register write needs no wait.
	task automatic write_register(input logic [0:0] index, input logic [4:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		sb.set_register(index, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [4:0] columns, input logic [4:0] rows);
		write_register(REG_COLUMNS, columns);
		write_register(REG_ROWS, rows);
	endtask

	// Sends one cost request. Valid is lowered only when a gap follows, so a
	// back-to-back request keeps valid high across the step.
	task automatic send_cost(input logic [15:0] value);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cost     <= value;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Holds off the sender until all assignments are back and the block has
	// had time to finish any work in flight.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.assignments.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// Draws a cost in one of several styles: many ties and zeros, the full
	// range, just the two extremes, or small values up to 40.
	function automatic logic [15:0] draw_cost(int style);
		case (style)
			0:       return 16'($urandom_range(0, 3));
			1:       return $urandom_range(0, 16'hFFFF);
			2:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(0, 40));
		endcase
	endfunction

	task automatic send_matrix(input int entries, input int style);
		for (int k = 0; k < entries; k++)
			send_cost(draw_cost(style));
	endtask

	initial begin
		int nr, nc, style;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. A one-by-one matrix with both cost extremes.
		configure(5'd1, 5'd1);
		send_cost(16'h0000);
		send_cost(16'hFFFF);
		drain();
		// Zero registers count as one.
		configure(5'd0, 5'd0);
		send_cost(16'h1234);
		drain();
		// More columns than rows: the columns are cut down to two.
		configure(5'd3, 5'd2);
		send_cost(16'd0);
		send_cost(16'd0);
		send_cost(16'd0);
		send_cost(16'd0);
		drain();
		// Ties in the first column, and a broken load ahead of a register write.
		configure(5'd2, 5'd3);
		send_cost(16'd5);
		send_cost(16'd5);
		send_cost(16'd5);
		send_cost(16'd5);
		send_cost(16'hFFFF);
		send_cost(16'd0);
		send_cost(16'd7);
		send_cost(16'd9);
		drain();

		// The largest matrix, with registers above the maximum.
		configure(5'd31, 5'd31);
		no_gaps = 1'b1;
		send_matrix(256, 3);
		drain();
		no_gaps = 1'b0;

		// Random part: mostly small matrices, register settings changed between
		// phases, sometimes with a half-loaded matrix left behind.
		while (random_requests < 480) begin
			nr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
			nc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
			configure(5'(nc), 5'(nr));
			no_gaps = ($urandom_range(0, 3) == 0);
			nr = sb.row_count();
			nc = sb.col_count();
			for (int m = $urandom_range(1, 4); m > 0; m--) begin
				style = $urandom_range(0, 3);
				send_matrix(nr * nc, style);
				random_requests += nr * nc;
				if ($urandom_range(0, 2) == 0)
					drain();
			end
			if ($urandom_range(0, 3) == 0) begin
				send_matrix($urandom_range(1, nr * nc), 1);
				random_requests++;
			end
			drain();
		end

		$display("Covered %0d cost requests and %0d solved matrices, sizes 1x1 up to 16x16,",
			sb.requests, sb.matrices);
		$display("with clamped and restarted settings, ties, zeros and both cost extremes.");
		if (sb.errors == 0 && sb.assignments.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end
endmodule

// ===== hungarian_assignment_solver_unit.f =====
rtl/has_pkg.sv
rtl/has_ram.sv
rtl/hungarian_assignment_solver_unit.sv
bench/testbench.sv
